// ----- rtl/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants of the frame checker
// Control characters, status codes and the result record of one transfer.
// ----------------------------------------------------------------------------
package sfc_pkg;

    // Framing control characters.
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_EOT = 8'h04;

    // Frame status codes carried on the closing result.
    localparam logic [2:0] ST_INFRAME  = 3'd0;
    localparam logic [2:0] ST_GOOD     = 3'd1;
    localparam logic [2:0] ST_LONG     = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_WIDTH    = 3'd4;

    // Frame length limit after reset.
    localparam logic [15:0] MAX_FRAME_RESET = 16'd256;

    // One result item.
    typedef struct packed {
        logic [7:0]  frame_byte;
        logic [15:0] position;
        logic        frame_end;
        logic [2:0]  status;
        logic        run_last;
    } result_t;

    // Up to two results caused by one input byte.
    typedef struct packed {
        logic    r0_valid;
        logic    r1_valid;
        result_t r0;
        result_t r1;
    } step_out_t;

    // Status of the output buffer seen by the input side.
    typedef struct packed {
        logic can_take;
        logic pending;
    } buf_stat_t;

endpackage

// ----- rtl/sfc_frame_fsm.sv -----
// ----------------------------------------------------------------------------
// sfc_frame_fsm: frame parser and checksum checker
// Holds the frame state and works out the results of one byte combinationally.
// ----------------------------------------------------------------------------
module sfc_frame_fsm
    import sfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic [7:0]  in_byte,
    input  logic [15:0] max_frame,
    output step_out_t   step_out
);

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_HEAD  = 2'd1;
    localparam logic [1:0] PH_TEXT  = 2'd2;
    localparam logic [1:0] PH_CHECK = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] index_reg, index_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] check_reg, check_next;
    logic [2:0]  digits_reg, digits_next;

    logic [31:0] masked_sum;
    logic        width_ok;

    // Value of a hex digit; any other character counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
            v = c[3:0] + 4'd9;
        return v;
    endfunction

    // Mask the text sum to the width given by the digit count.
    always_comb
    begin
        masked_sum = sum_reg;
        width_ok   = 1'b1;
        case (digits_reg)
            3'd1:    masked_sum = {24'd0, sum_reg[7:0]};
            3'd2:    masked_sum = {16'd0, sum_reg[15:0]};
            3'd4:    masked_sum = sum_reg;
            default: width_ok = 1'b0;
        endcase
    end

    // Next state and results of the current byte.
    always_comb
    begin
        phase_next  = phase_reg;
        index_next  = index_reg;
        sum_next    = sum_reg;
        check_next  = check_reg;
        digits_next = digits_reg;
        step_out    = '0;

        if (phase_reg != PH_HUNT && index_reg >= max_frame)
        begin
            // The frame is full: close it, then rescan the byte for a start.
            step_out.r0_valid = 1'b1;
            step_out.r0 = '{frame_byte: in_byte, position: index_reg,
                            frame_end: 1'b1, status: ST_LONG,
                            run_last: (in_byte != CH_SOH)};
            phase_next = PH_HUNT;
            index_next = 16'd0;
            if (in_byte == CH_SOH)
            begin
                step_out.r1_valid = 1'b1;
                step_out.r1 = '{frame_byte: in_byte, position: 16'd0,
                                frame_end: 1'b0, status: ST_INFRAME,
                                run_last: 1'b1};
                phase_next  = PH_HEAD;
                index_next  = 16'd1;
                sum_next    = 32'd0;
                check_next  = 32'd0;
                digits_next = 3'd0;
            end
        end
        else
        begin
            unique case (phase_reg) inside
                PH_HUNT:
                begin
                    if (in_byte == CH_SOH)
                    begin
                        step_out.r0_valid = 1'b1;
                        step_out.r0 = '{frame_byte: in_byte, position: 16'd0,
                                        frame_end: 1'b0, status: ST_INFRAME,
                                        run_last: 1'b1};
                        phase_next  = PH_HEAD;
                        index_next  = 16'd1;
                        sum_next    = 32'd0;
                        check_next  = 32'd0;
                        digits_next = 3'd0;
                    end
                end
                PH_HEAD, PH_TEXT, PH_CHECK:
                begin
                    step_out.r0_valid = 1'b1;
                    step_out.r0 = '{frame_byte: in_byte, position: index_reg,
                                    frame_end: 1'b0, status: ST_INFRAME,
                                    run_last: 1'b1};
                    index_next = index_reg + 16'd1;
                    if (phase_reg == PH_HEAD)
                    begin
                        if (in_byte == CH_STX) phase_next = PH_TEXT;
                    end
                    else if (phase_reg == PH_TEXT)
                    begin
                        if (in_byte == CH_ETX) phase_next = PH_CHECK;
                        else sum_next = sum_reg + {24'd0, in_byte};
                    end
                    else if (in_byte == CH_EOT)
                    begin
                        // End of frame: judge the checksum.
                        step_out.r0.frame_end = 1'b1;
                        if (!width_ok)
                            step_out.r0.status = ST_WIDTH;
                        else if (masked_sum == check_reg)
                            step_out.r0.status = ST_GOOD;
                        else
                            step_out.r0.status = ST_MISMATCH;
                        phase_next = PH_HUNT;
                        index_next = 16'd0;
                    end
                    else
                    begin
                        check_next = {check_reg[27:0], hex_value(in_byte)};
                        if (digits_reg != 3'd7) digits_next = digits_reg + 3'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // Frame state registers, updated when a byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            index_reg  <= 16'd0;
            sum_reg    <= 32'd0;
            check_reg  <= 32'd0;
            digits_reg <= 3'd0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            index_reg  <= index_next;
            sum_reg    <= sum_next;
            check_reg  <= check_next;
            digits_reg <= digits_next;
        end
    end

endmodule

// ----- rtl/sfc_out_buf.sv -----
// ----------------------------------------------------------------------------
// sfc_out_buf: two-entry result register for the output stream
// Takes one or two results at a time and hands them out in order.
// ----------------------------------------------------------------------------
module sfc_out_buf
    import sfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  step_out_t   step_out,
    output buf_stat_t   stat,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output result_t     head
);

    logic    slot0_valid_reg;
    logic    slot1_valid_reg;
    result_t slot0_reg;
    result_t slot1_reg;
    logic    slot0_free;

    assign slot0_free    = !slot0_valid_reg || m_axis_tready;
    assign stat.can_take = slot0_free && !slot1_valid_reg;
    assign stat.pending  = slot1_valid_reg;
    assign m_axis_tvalid = slot0_valid_reg;
    assign head          = slot0_reg;

    // Valid bits: the second slot only ever drains into the first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot0_valid_reg <= 1'b0;
            slot1_valid_reg <= 1'b0;
        end
        else if (slot1_valid_reg)
        begin
            if (slot0_free)
            begin
                slot0_valid_reg <= 1'b1;
                slot1_valid_reg <= 1'b0;
            end
        end
        else if (push && step_out.r0_valid)
        begin
            slot0_valid_reg <= 1'b1;
            slot1_valid_reg <= step_out.r1_valid;
        end
        else if (m_axis_tready)
        begin
            slot0_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (slot1_valid_reg)
        begin
            if (slot0_free) slot0_reg <= slot1_reg;
        end
        else if (push && step_out.r0_valid)
        begin
            slot0_reg <= step_out.r0;
            slot1_reg <= step_out.r1;
        end
    end

endmodule

// ----- rtl/soh_stx_etx_eot_frame_checker_unit.sv -----
// ----------------------------------------------------------------------------
// soh_stx_etx_eot_frame_checker_unit: SOH/STX/ETX/EOT frame checker
// Parses a received byte stream into frames and checks the text checksum.
// ----------------------------------------------------------------------------
// The unit accepts a new received byte every clock cycle. A byte passes an
// input register and the frame parser; its results enter the output register
// as it leaves the input register. A non-SOH byte outside a frame gives no
// result; a frame byte gives one result. An SOH that finds the frame full
// gives two results (the abort and the new frame start); the two-entry
// output register holds the input until the second drains. Output
// backpressure stalls the input. The user must write the frame length limit
// (cfg_wen/cfg_wdata) only while idle; the block does not enforce this.
module soh_stx_etx_eot_frame_checker_unit
    import sfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,       // max_frame
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [7:0] frame_byte, [23:8] position,
                                         // [24] frame_end, [27:25] status, zero
    output logic        m_axis_tlast     // run_last
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] max_frame_reg;
    logic        consume;
    step_out_t   step_out;
    buf_stat_t   buf_stat;
    result_t     head;

    // A byte leaves the input register when the output side can take its results.
    assign consume       = in_valid_reg && buf_stat.can_take;
    assign s_axis_tready = !in_valid_reg || consume;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_frame_reg <= MAX_FRAME_RESET;
        else if (cfg_wen)
            max_frame_reg <= cfg_wdata;
    end

    // Input register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_byte_reg <= s_axis_tdata;
    end

    sfc_frame_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (consume),
        .in_byte   (in_byte_reg),
        .max_frame (max_frame_reg),
        .step_out  (step_out)
    );

    sfc_out_buf u_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (consume),
        .step_out      (step_out),
        .stat          (buf_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .head          (head)
    );

    // Output packing.
    assign m_axis_tdata = {4'd0, head.status, head.frame_end, head.position,
                           head.frame_byte};
    assign m_axis_tlast = head.run_last;

    // A held second result always sits behind a valid first one.
    assert property (@(posedge clk) disable iff (!rst_n)
        buf_stat.pending |-> m_axis_tvalid)
        else $error("second result held without a first");

    // The input only stalls while it holds a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg)
        else $error("input stalled while empty");

    // Only a closing result carries a frame status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[24]) |-> (m_axis_tdata[27:25] == ST_INFRAME))
        else $error("status on a result that does not close the frame");

    // A frame opens at position zero with the start byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[23:8] == 16'd0 && !m_axis_tdata[24])
            |-> (m_axis_tdata[7:0] == CH_SOH))
        else $error("frame start without a start byte");

endmodule

// ----- tb/frame_echo_checker.sv -----
// ----------------------------------------------------------------------------
// frame_echo_checker: result predictor and comparator for the frame checker
// Watches the configuration port and both stream channels. Every byte transfer
// on the input runs through a frame parser of its own, which queues the echo
// results that byte should cause. Every result transfer is compared field by
// field with the oldest queued echo.
// ----------------------------------------------------------------------------
module frame_echo_checker
    import sfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wen,
    input  logic [15:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          echoes_pending,
    output int          error_count
);

    typedef enum logic [2:0] {SCAN_HUNT, SCAN_HEAD, SCAN_TEXT, SCAN_CHECK} scan_t;

    // Parser state kept in step with the block.
    logic [15:0] frame_limit;
    scan_t       scan;
    logic [15:0] next_pos;
    logic [31:0] text_total;
    logic [31:0] check_value;
    logic [2:0]  check_digits;

    result_t     echo_q[$];
    int          errors = 0;

    // Value of one checksum character; anything that is not a hex digit is zero.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return 4'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46)
            return 4'(c - 8'h41 + 8'd10);
        if (c >= 8'h61 && c <= 8'h66)
            return 4'(c - 8'h61 + 8'd10);
        return 4'd0;
    endfunction

    function automatic result_t make_echo(input logic [7:0] b, input logic [15:0] pos,
                                          input logic fin, input logic [2:0] st);
        result_t r;
        r.frame_byte = b;
        r.position   = pos;
        r.frame_end  = fin;
        r.status     = st;
        r.run_last   = 1'b0;
        return r;
    endfunction

    // Advance the parser by one received byte and queue the echoes it causes.
    task automatic take_rx_byte(input logic [7:0] b);
        result_t     res [2];
        int          n;
        logic [31:0] masked;
        n = 0;
        masked = '0;

        // A byte that finds the frame full closes it and is then rescanned.
        if (scan != SCAN_HUNT && next_pos >= frame_limit) begin
            res[0]   = make_echo(b, next_pos, 1'b1, ST_LONG);
            n        = 1;
            scan     = SCAN_HUNT;
            next_pos = '0;
        end

        if (scan == SCAN_HUNT) begin
            if (b == CH_SOH) begin
                res[n]       = make_echo(b, 16'd0, 1'b0, ST_INFRAME);
                n            = n + 1;
                scan         = SCAN_HEAD;
                next_pos     = 16'd1;
                text_total   = '0;
                check_value  = '0;
                check_digits = '0;
            end
        end else begin
            res[0]   = make_echo(b, next_pos, 1'b0, ST_INFRAME);
            n        = 1;
            next_pos = next_pos + 16'd1;
            case (scan)
                SCAN_HEAD:
                begin
                    if (b == CH_STX)
                        scan = SCAN_TEXT;
                end
                SCAN_TEXT:
                begin
                    if (b == CH_ETX)
                        scan = SCAN_CHECK;
                    else
                        text_total = text_total + 32'(b);
                end
                default:
                begin
                    if (b == CH_EOT) begin
                        // The digit count picks how much of the sum is compared.
                        res[0].frame_end = 1'b1;
                        case (check_digits)
                            3'd1:    masked = text_total & 32'h0000_00ff;
                            3'd2:    masked = text_total & 32'h0000_ffff;
                            default: masked = text_total;
                        endcase
                        if (check_digits != 3'd1 && check_digits != 3'd2 &&
                            check_digits != 3'd4)
                            res[0].status = ST_WIDTH;
                        else if (masked == check_value)
                            res[0].status = ST_GOOD;
                        else
                            res[0].status = ST_MISMATCH;
                        scan     = SCAN_HUNT;
                        next_pos = '0;
                    end else begin
                        check_value = {check_value[27:0], hex_nibble(b)};
                        if (check_digits != 3'd7)
                            check_digits = check_digits + 3'd1;
                    end
                end
            endcase
        end

        if (n > 0)
            res[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++)
            echo_q.push_back(res[i]);
    endtask

    task automatic report_field(input string name, input int unsigned want_v,
                                input int unsigned got_v);
        errors = errors + 1;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    endtask

    // Track configuration and input transfers, then check result transfers.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            frame_limit  = MAX_FRAME_RESET;
            scan         = SCAN_HUNT;
            next_pos     = '0;
            text_total   = '0;
            check_value  = '0;
            check_digits = '0;
            echo_q.delete();
            echoes_pending <= 0;
        end else begin
            if (cfg_wen)
                frame_limit = cfg_wdata;

            if (s_axis_tvalid && s_axis_tready)
                take_rx_byte(s_axis_tdata);

            if (m_axis_tvalid && m_axis_tready) begin
                if (echo_q.size() == 0) begin
                    errors = errors + 1;
                    $display("%0t: unexpected result, expected none, actual tdata %08h last %0b",
                             $time, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = echo_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.frame_byte)
                        report_field("frame_byte", want.frame_byte, m_axis_tdata[7:0]);
                    if (m_axis_tdata[23:8] !== want.position)
                        report_field("position", want.position, m_axis_tdata[23:8]);
                    if (m_axis_tdata[24] !== want.frame_end)
                        report_field("frame_end", want.frame_end, m_axis_tdata[24]);
                    if (m_axis_tdata[27:25] !== want.status)
                        report_field("status", want.status, m_axis_tdata[27:25]);
                    if (m_axis_tdata[31:28] !== 4'd0)
                        report_field("tdata padding", 0, m_axis_tdata[31:28]);
                    if (m_axis_tlast !== want.run_last)
                        report_field("run_last", want.run_last, m_axis_tlast);
                end
            end
            echoes_pending <= echo_q.size();
        end
        error_count <= errors;
    end

endmodule

// ----- tb/soh_stx_etx_eot_frame_checker_unit_tb.sv -----
// ----------------------------------------------------------------------------
// soh_stx_etx_eot_frame_checker_unit_tb: stream test of the frame checker
// Sends a short directed byte sequence, then random frames, broken frames and
// line noise under several frame length limits, with random gaps on the input
// and random stalls on the output. The echo checker beside the block predicts
// and compares every result; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module soh_stx_etx_eot_frame_checker_unit_tb;
    import sfc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_BYTES   = 230;
    localparam int SETTLE_CYCLES = 4;
    localparam int NUM_PHASES    = 7;

    // Opening sequence: noise while hunting, a good four-digit frame with
    // control bytes inside header and text, a frame whose checksum holds a
    // non-hex character, and a frame that ends with no checksum digits.
    localparam logic [7:0] OPENING [26] = '{
        8'h00, 8'hff, CH_EOT,
        CH_SOH, CH_SOH, 8'hff, CH_STX, 8'hff, CH_SOH, CH_ETX,
        8'h30, 8'h31, 8'h30, 8'h30, CH_EOT,
        CH_SOH, CH_STX, 8'hfe, CH_ETX, 8'h7a, 8'h45, CH_EOT,
        CH_SOH, CH_STX, CH_ETX, CH_EOT
    };

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_wen       = 1'b0;
    logic [15:0] cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    int          echoes_pending;
    int          error_count;
    int          cycle_count = 0;
    int          rx_hold     = 0;
    int          frame_bytes = 0;
    bit          tx_calm     = 1'b1;
    bit          rx_calm     = 1'b1;

    soh_stx_etx_eot_frame_checker_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    frame_echo_checker echo_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .echoes_pending (echoes_pending),
        .error_count    (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output side: ready drops in random bursts.
    always @(posedge clk)
    begin
        if (!rx_calm && rx_hold == 0 && $urandom_range(0, 5) == 0) begin
            rx_hold       <= $urandom_range(1, 10) - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("soh_stx_etx_eot_frame_checker_unit_tb: done, errors");
            $finish;
        end
    end

    // One byte transfer, sometimes after a random gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!tx_calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_frame_byte(input logic [7:0] b);
        send_byte(b);
        frame_bytes = frame_bytes + 1;
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (echoes_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [15:0] limit);
        cfg_wdata <= limit;
        cfg_wen   <= 1'b1;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // A complete frame with random header and text, and a checksum that is
    // usually right but may have the wrong width or a corrupted character.
    task automatic send_frame();
        int          n_head;
        int          n_text;
        int          n_digits;
        int          i;
        bit          narrow;
        logic [7:0]  b;
        logic [3:0]  nib;
        logic [31:0] total;
        total  = '0;
        n_head = $urandom_range(0, 3);
        n_text = $urandom_range(0, 6);
        narrow = 1'($urandom_range(0, 1));

        send_frame_byte(CH_SOH);
        repeat (n_head) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_STX)
                b = 8'h20;
            send_frame_byte(b);
        end
        send_frame_byte(CH_STX);
        repeat (n_text) begin
            b = narrow ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
            if (b == CH_ETX)
                b = 8'h33;
            total = total + 32'(b);
            send_frame_byte(b);
        end
        send_frame_byte(CH_ETX);

        case ($urandom_range(0, 9)) inside
            0:       n_digits = 0;
            1:       n_digits = 3;
            2:       n_digits = $urandom_range(5, 9);
            [3:4]:   n_digits = 1;
            [5:6]:   n_digits = 2;
            default: n_digits = 4;
        endcase
        for (i = n_digits - 1; i >= 0; i--) begin
            nib = 4'(total >> (4 * i));
            if (nib < 4'd10)
                b = 8'h30 + 8'(nib);
            else if ($urandom_range(0, 1) == 1)
                b = 8'h41 + 8'(nib) - 8'd10;
            else
                b = 8'h61 + 8'(nib) - 8'd10;
            if ($urandom_range(0, 11) == 0) begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_EOT)
                    b = 8'h47;
            end
            send_frame_byte(b);
        end
        send_frame_byte(CH_EOT);
    endtask

    // A start byte followed by a few bytes heavy in control characters, which
    // may by chance close the frame but usually leave it unfinished.
    task automatic send_broken_frame();
        int         len;
        logic [7:0] b;
        len = $urandom_range(1, 6);
        send_frame_byte(CH_SOH);
        repeat (len) begin
            case ($urandom_range(0, 3))
                0:       b = CH_SOH;
                1:       b = 8'($urandom_range(1, 4));
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_frame_byte(b);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [15:0] limits [NUM_PHASES];
        int          pick;
        int          p;
        bit          last_phase;
        limits = '{16'd0, 16'd1, 16'hffff, 16'd9, 16'd256, 16'd30, 16'd0};
        limits[NUM_PHASES - 1] = 16'($urandom_range(2, 64));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_calm = 1'b0;
        rx_calm = 1'b0;
        foreach (OPENING[i])
            send_byte(OPENING[i]);

        for (p = 0; p < NUM_PHASES; p++) begin
            // The block is idle here, possibly in the middle of a frame.
            wait_drained();
            write_limit(limits[p]);
            last_phase  = (p == NUM_PHASES - 1);
            tx_calm     = last_phase || $urandom_range(0, 3) == 0;
            rx_calm     = last_phase || $urandom_range(0, 3) == 0;
            frame_bytes = 0;
            while (frame_bytes < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    send_frame();
                else if (pick < 87)
                    send_broken_frame();
                else
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
            if (!last_phase && $urandom_range(0, 1) == 1)
                send_broken_frame();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("soh_stx_etx_eot_frame_checker_unit_tb: done, clean");
        else
            $display("soh_stx_etx_eot_frame_checker_unit_tb: done, errors");
        $finish;
    end

endmodule
